FILE: rtl/lz77_window_decompressor_macros.svh
// Assertion macros shared by the lz77_window_decompressor RTL.
// No dependencies; files that check their own logic include this header.
`ifndef LZ77_WINDOW_DECOMPRESSOR_MACROS_SVH
`define LZ77_WINDOW_DECOMPRESSOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LZWD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define LZWD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lzwd_pkg.sv
// Shared constants and controller/datapath interface types for the LZ77 decompressor.
// No dependencies.
`timescale 1ns / 1ps

package lzwd_pkg;

    localparam int LZWD_DEPTH   = 4096;          // history window bytes
    localparam int LZWD_PTR_W   = 12;            // ring pointer width
    localparam int LZWD_SIZE_W  = 24;            // declared size width
    localparam int LZWD_CNT_W   = 5;             // copy length counter (3..18)
    localparam int LZWD_FLAG_W  = 4;             // flags-left counter

    localparam logic [7:0]             LZWD_TYPE_LZ77  = 8'h10;
    localparam logic [LZWD_CNT_W-1:0]  LZWD_MIN_MATCH  = 5'd3;
    localparam logic [LZWD_FLAG_W-1:0] LZWD_GROUP_SIZE = 4'd8;

    // Controller -> datapath commands
    typedef struct packed {
        logic clr_block;   // block start: drop flags, declared size and remaining count
        logic ld_size0;
        logic ld_size1;
        logic ld_size2;
        logic ld_flags;
        logic ld_tok;      // first token byte
        logic ld_dist;     // second token byte: set source pointer and length
        logic rd_ring;     // read history at source pointer
        logic emit_lit;
        logic emit_copy;
        logic emit_err;
        logic emit_empty;
        logic adv_flag;    // item done: shift flag byte
    } t_lzwd_cmd;

    // Datapath -> controller status
    typedef struct packed {
        logic out_free;    // output register can take a result this cycle
        logic hdr_ok;      // input byte is the LZ77 type code
        logic size_zero;   // declared size with this byte is zero
        logic flag_msb;    // current item is a token
        logic last_flag;   // this is the last item of the flag group
        logic rem_one;     // one output byte left in the block
        logic cnt_one;     // one byte left in the current copy
    } t_lzwd_status;

endpackage

FILE: rtl/lzwd_datapath.sv
// Datapath of the LZ77 decompressor: 4 KiB history ring, block counters,
// flag shifter, copy pointer and output register. Depends on lzwd_pkg.
`timescale 1ns / 1ps
`include "lz77_window_decompressor_macros.svh"

module lzwd_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lzwd_pkg::t_lzwd_cmd   i_cmd,
    output lzwd_pkg::t_lzwd_status o_status,
    input  logic [7:0]            i_byte,
    input  logic                  i_m_tready,
    output logic                  o_m_tvalid,
    output logic [7:0]            o_out_byte,
    output logic                  o_last,
    output logic                  o_eob,
    output logic                  o_err,
    output logic [lzwd_pkg::LZWD_SIZE_W-1:0] o_size
);
    import lzwd_pkg::*;

    logic [7:0]             r_ring [LZWD_DEPTH];
    logic [7:0]             r_rdata;
    logic [LZWD_PTR_W-1:0]  r_wp;
    logic [LZWD_PTR_W-1:0]  r_src;
    logic [LZWD_SIZE_W-1:0] r_remaining;
    logic [LZWD_SIZE_W-1:0] r_declared;
    logic [7:0]             r_flag_bits;
    logic [LZWD_FLAG_W-1:0] r_flags_left;
    logic [7:0]             r_tok;
    logic [LZWD_CNT_W-1:0]  r_count;
    logic                   r_ovalid;
    logic [7:0]             r_obyte;
    logic                   r_olast;
    logic                   r_oeob;
    logic                   r_oerr;
    logic [LZWD_SIZE_W-1:0] r_osize;

    logic                   emit_data;
    logic                   emit_any;
    logic [7:0]             wr_byte;

    assign emit_data = i_cmd.emit_lit | i_cmd.emit_copy;
    assign emit_any  = emit_data | i_cmd.emit_err | i_cmd.emit_empty;
    assign wr_byte   = i_cmd.emit_copy ? r_rdata : i_byte;

    always_comb begin
        o_status.out_free  = !r_ovalid || i_m_tready;
        o_status.hdr_ok    = (i_byte == LZWD_TYPE_LZ77);
        o_status.size_zero = ({i_byte, r_declared[15:0]} == '0);
        o_status.flag_msb  = r_flag_bits[7];
        o_status.last_flag = (r_flags_left == 4'd1);
        o_status.rem_one   = (r_remaining == 24'd1);
        o_status.cnt_one   = (r_count == 5'd1);
    end

    // history ring: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (emit_data) begin
            r_ring[r_wp] <= wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_ring) begin
            r_rdata <= r_ring[r_src];
        end
    end

    // block and flag state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp         <= '0;
            r_remaining  <= '0;
            r_declared   <= '0;
            r_flag_bits  <= '0;
            r_flags_left <= '0;
        end else begin
            if (i_cmd.clr_block) begin
                r_remaining  <= '0;
                r_declared   <= '0;
                r_flag_bits  <= '0;
                r_flags_left <= '0;
            end
            if (i_cmd.ld_size0) begin
                r_declared <= {16'd0, i_byte};
            end
            if (i_cmd.ld_size1) begin
                r_declared[15:8] <= i_byte;
            end
            if (i_cmd.ld_size2) begin
                r_declared[23:16] <= i_byte;
                r_remaining       <= {i_byte, r_declared[15:0]};
            end
            if (i_cmd.ld_flags) begin
                r_flag_bits  <= i_byte;
                r_flags_left <= LZWD_GROUP_SIZE;
            end
            if (emit_data) begin
                r_wp        <= r_wp + 12'd1;
                r_remaining <= r_remaining - 24'd1;
            end
            if (i_cmd.adv_flag) begin
                r_flag_bits  <= {r_flag_bits[6:0], 1'b0};
                r_flags_left <= r_flags_left - 4'd1;
            end
        end
    end

    // token registers: source pointer walks with the write pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_tok) begin
            r_tok <= i_byte;
        end
        if (i_cmd.ld_dist) begin
            r_src   <= r_wp - {r_tok[3:0], i_byte} - 12'd1;
            r_count <= {1'b0, r_tok[7:4]} + LZWD_MIN_MATCH;
        end
        if (i_cmd.emit_copy) begin
            r_src   <= r_src + 12'd1;
            r_count <= r_count - 5'd1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (emit_any) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_any) begin
            r_obyte <= emit_data ? wr_byte : 8'd0;
            r_olast <= i_cmd.emit_copy ? (o_status.cnt_one | o_status.rem_one) : 1'b1;
            r_oeob  <= i_cmd.emit_empty | (emit_data & o_status.rem_one);
            r_oerr  <= i_cmd.emit_err;
            r_osize <= emit_data ? r_declared : '0;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_out_byte = r_obyte;
    assign o_last     = r_olast;
    assign o_eob      = r_oeob;
    assign o_err      = r_oerr;
    assign o_size     = r_osize;

    `LZWD_ASSERT_NOW(a_emit_needs_room, emit_any, o_status.out_free, "result emitted into a full output register")
    `LZWD_ASSERT_NEXT(a_emit_sets_valid, emit_any, r_ovalid, "emitted result not presented")

endmodule

FILE: rtl/lzwd_ctrl.sv
// Controller of the LZ77 decompressor: header, flag group, item and copy sequencing.
// Depends on lzwd_pkg.
`timescale 1ns / 1ps
`include "lz77_window_decompressor_macros.svh"

module lzwd_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    input  logic                   i_start,
    output logic                   o_s_tready,
    input  lzwd_pkg::t_lzwd_status i_status,
    output lzwd_pkg::t_lzwd_cmd    o_cmd
);
    import lzwd_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SIZE0, S_SIZE1, S_SIZE2, S_FLAGS, S_ITEM, S_TOKEN,
        S_COPY_RD, S_COPY_WR
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state after_item;
    logic   in_phase;
    logic   acc;

    assign in_phase   = (r_state != S_COPY_RD) && (r_state != S_COPY_WR);
    assign o_s_tready = in_phase && i_status.out_free;
    assign acc        = i_s_tvalid && o_s_tready;

    always_comb begin
        if (i_status.rem_one) begin
            after_item = S_IDLE;
        end else if (i_status.last_flag) begin
            after_item = S_FLAGS;
        end else begin
            after_item = S_ITEM;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        if (acc && i_start) begin
            o_cmd.clr_block = 1'b1;
            if (i_status.hdr_ok) begin
                n_state = S_SIZE0;
            end else begin
                o_cmd.emit_err = 1'b1;
                n_state        = S_IDLE;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    n_state = S_IDLE;
                end
                S_SIZE0: begin
                    if (acc) begin
                        o_cmd.ld_size0 = 1'b1;
                        n_state        = S_SIZE1;
                    end
                end
                S_SIZE1: begin
                    if (acc) begin
                        o_cmd.ld_size1 = 1'b1;
                        n_state        = S_SIZE2;
                    end
                end
                S_SIZE2: begin
                    if (acc) begin
                        o_cmd.ld_size2 = 1'b1;
                        if (i_status.size_zero) begin
                            o_cmd.emit_empty = 1'b1;
                            n_state          = S_IDLE;
                        end else begin
                            n_state = S_FLAGS;
                        end
                    end
                end
                S_FLAGS: begin
                    if (acc) begin
                        o_cmd.ld_flags = 1'b1;
                        n_state        = S_ITEM;
                    end
                end
                S_ITEM: begin
                    if (acc) begin
                        if (i_status.flag_msb) begin
                            o_cmd.ld_tok = 1'b1;
                            n_state      = S_TOKEN;
                        end else begin
                            o_cmd.emit_lit = 1'b1;
                            o_cmd.adv_flag = 1'b1;
                            n_state        = after_item;
                        end
                    end
                end
                S_TOKEN: begin
                    if (acc) begin
                        o_cmd.ld_dist = 1'b1;
                        n_state       = S_COPY_RD;
                    end
                end
                S_COPY_RD: begin
                    o_cmd.rd_ring = 1'b1;
                    n_state       = S_COPY_WR;
                end
                S_COPY_WR: begin
                    if (i_status.out_free) begin
                        o_cmd.emit_copy = 1'b1;
                        if (i_status.cnt_one || i_status.rem_one) begin
                            o_cmd.adv_flag = 1'b1;
                            n_state        = after_item;
                        end else begin
                            n_state = S_COPY_RD;
                        end
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `LZWD_ASSERT_NEXT(a_read_then_write, r_state == S_COPY_RD, r_state == S_COPY_WR, "copy read not followed by write")
    `LZWD_ASSERT_NEXT(a_copy_continues, o_cmd.emit_copy && !o_cmd.adv_flag, r_state == S_COPY_RD, "copy stopped early")
    `LZWD_ASSERT_NOW(a_no_input_in_copy, r_state == S_COPY_RD || r_state == S_COPY_WR, !o_s_tready, "input taken during copy")

endmodule

FILE: rtl/lz77_window_decompressor.sv
// Top level of the LZ77 (type 0x10) decompressor with a 4 KiB history window.
// Depends on lzwd_pkg, lzwd_ctrl and lzwd_datapath.
//
//   channel  | dir | tdata                          | tuser                        | tlast
//   ---------+-----+--------------------------------+------------------------------+------------
//   s_axis   | in  | [7:0] compressed byte          | [0] start of block           | -
//   m_axis   | out | [7:0] byte, [31:8] block size  | [0] end of block, [1] hdr err| last of run
//
// Sequencing: header, flag and first token bytes are taken into registers; a literal
// byte is written to the ring and the result register together; a token second
// byte starts a copy in which each output byte passes a ring read state, then a
// ring write and output state, as set by the single registered read port of the
// history ring.
// Reset: synchronous active-low; the ring itself is not cleared.
// Stalls: the result register holds until its transfer; input is taken only
// while that register is free or being emptied, and never during a copy.
`timescale 1ns / 1ps

module lz77_window_decompressor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] in_byte
    input  logic        i_s_axis_tuser,   // [0] start_of_block
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [7:0] out_byte, [31:8] block_size
    output logic [1:0]  o_m_axis_tuser,   // [0] end_of_block, [1] header_error
    output logic        o_m_axis_tlast    // last_of_run
);
    import lzwd_pkg::*;

    t_lzwd_cmd              cmd;
    t_lzwd_status           status;
    logic [7:0]             out_byte;
    logic                   eob;
    logic                   err;
    logic [LZWD_SIZE_W-1:0] size;

    // sequencing: header, flag groups, items and copy steps
    lzwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_start    (i_s_axis_tuser),
        .o_s_tready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // ring, counters and result register
    lzwd_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_byte     (i_s_axis_tdata),
        .i_m_tready (i_m_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .o_out_byte (out_byte),
        .o_last     (o_m_axis_tlast),
        .o_eob      (eob),
        .o_err      (err),
        .o_size     (size)
    );

    assign o_m_axis_tdata = {size, out_byte};
    assign o_m_axis_tuser = {err, eob};

endmodule
